// ----- hdl/srmc_pkg.sv -----
// shared types, constants and arithmetic helpers of the sphere reflection map coordinate pipeline
package srmc_pkg;

   // geometry and number format
   localparam int SPHERE_RADIUS = 255;
   localparam int RADIUS_SQ     = SPHERE_RADIUS * SPHERE_RADIUS;
   localparam int FRAC_BITS     = 15;
   localparam int ONE           = 1 << FRAC_BITS;

   // angle units: 2^-20 turn
   localparam int ANG_BITS      = 20;
   localparam int HALF_TURN     = 1 << (ANG_BITS - 1);
   localparam int QUARTER_TURN  = 1 << (ANG_BITS - 2);
   localparam int CORDIC_STEPS  = 18;
   localparam int SCALE_SHIFT   = 44 - FRAC_BITS;

   // map width as a shift against one turn, map height in rows
   localparam int COL_SHIFT     = 10;
   localparam int MAP_HEIGHT    = 512;

   // reciprocals for the constant divisions (error below one, fixed by one compare)
   localparam int NZ_SHIFT  = 32;
   localparam logic [31:0] NZ_RECIP  = 32'((64'd1 << 47) / 64'(RADIUS_SQ));
   localparam int LAT_SHIFT = 34;
   localparam logic [25:0] LAT_RECIP = 26'((64'd1 << 34) / 64'(2 * SPHERE_RADIUS));
   localparam int RZ_SHIFT  = 34;
   localparam logic [17:0] RZ_RECIP  = 18'((64'd1 << 34) / 64'(2 * RADIUS_SQ));

   // square root digit state
   typedef struct packed {
      logic [17:0] rem;
      logic [15:0] root;
   } sqrt_type;

   // vectoring rotator state
   typedef struct packed {
      logic signed [47:0] x;
      logic signed [47:0] y;
      logic signed [21:0] acc;
   } cordic_type;

   // one item as it travels down the pipeline
   typedef struct packed {
      logic              in_disc;
      logic              sx;
      logic              sy;
      logic [8:0]        ax;
      logic [8:0]        ay;
      logic [17:0]       d2;
      logic [15:0]       t;
      logic [15:0]       qe;
      logic [15:0]       anum;
      logic              nneg;
      logic [31:0]       p2;
      logic [15:0]       rzq;
      logic [31:0]       sq_n;
      sqrt_type          sq;
      logic [24:0]       px;
      logic [24:0]       py;
      logic [16:0]       qx;
      logic [16:0]       qy;
      logic signed [16:0] rx;
      logic signed [16:0] ry;
      logic signed [16:0] rz;
      logic              az_zero;
      logic              inc_zero;
      cordic_type        az;
      cordic_type        inc;
      logic [15:0]       o_rx;
      logic [15:0]       o_ry;
      logic [15:0]       o_rz;
      logic [7:0]        o_cx;
      logic [7:0]        o_cy;
      logic [7:0]        o_cz;
      logic [9:0]        o_col;
      logic [8:0]        o_row;
   } item_type;

   // arctangent of 2^-i in angle units
   function automatic logic signed [21:0] atan_entry(int i);
      logic signed [21:0] v;
      case (i)
         0:  v = 22'sd131072;
         1:  v = 22'sd77376;
         2:  v = 22'sd40884;
         3:  v = 22'sd20753;
         4:  v = 22'sd10417;
         5:  v = 22'sd5213;
         6:  v = 22'sd2607;
         7:  v = 22'sd1304;
         8:  v = 22'sd652;
         9:  v = 22'sd326;
         10: v = 22'sd163;
         11: v = 22'sd81;
         12: v = 22'sd41;
         13: v = 22'sd20;
         14: v = 22'sd10;
         15: v = 22'sd5;
         16: v = 22'sd3;
         17: v = 22'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // one digit of the restoring square root
   function automatic sqrt_type sqrt_step(sqrt_type s, logic [1:0] bits);
      sqrt_type   o;
      logic [19:0] r4;
      logic [19:0] trial;
      r4    = {s.rem, bits};
      trial = {2'b00, s.root, 2'b01};
      if (r4 >= trial) begin
         o.rem  = 18'(r4 - trial);
         o.root = {s.root[14:0], 1'b1};
      end else begin
         o.rem  = 18'(r4);
         o.root = {s.root[14:0], 1'b0};
      end
      return o;
   endfunction

   // scaling and quarter-turn pre-rotation of atan2(b, a)
   function automatic cordic_type cordic_init(logic signed [16:0] a, logic signed [16:0] b);
      cordic_type         o;
      logic signed [47:0] xx;
      logic signed [47:0] yy;
      xx = 48'(a) <<< SCALE_SHIFT;
      yy = 48'(b) <<< SCALE_SHIFT;
      if (xx < 0) begin
         if (yy >= 0) begin
            o.x   = yy;
            o.y   = -xx;
            o.acc = 22'(QUARTER_TURN);
         end else begin
            o.x   = -yy;
            o.y   = xx;
            o.acc = -22'(QUARTER_TURN);
         end
      end else begin
         o.x   = xx;
         o.y   = yy;
         o.acc = '0;
      end
      return o;
   endfunction

   // one micro-rotation, floor shifts
   function automatic cordic_type cordic_step(cordic_type c, int i);
      cordic_type         o;
      logic signed [47:0] dx;
      logic signed [47:0] dy;
      dx = c.y >>> i;
      dy = c.x >>> i;
      if (c.y > 0) begin
         o.x   = c.x + dx;
         o.y   = c.y - dy;
         o.acc = c.acc + atan_entry(i);
      end else begin
         o.x   = c.x - dx;
         o.y   = c.y + dy;
         o.acc = c.acc - atan_entry(i);
      end
      return o;
   endfunction

   // rounded lateral component after the reciprocal estimate, with sign
   function automatic logic signed [16:0] lat_fix(logic [24:0] p, logic [16:0] q, logic neg);
      logic [25:0] rem;
      logic [16:0] m;
      rem = 26'(p) - 26'(q) * 26'(2 * SPHERE_RADIUS);
      m   = (rem >= 26'(2 * SPHERE_RADIUS)) ? 17'(q + 17'd1) : q;
      if (m > 17'(ONE)) m = 17'(ONE);
      return neg ? -$signed(m) : $signed(m);
   endfunction

   // byte colour code of a component
   function automatic logic [7:0] colour(logic signed [16:0] c);
      logic [17:0] v;
      logic [25:0] p;
      v = 18'($signed({c[16], c}) + 18'sd32768);
      p = {v, 8'b0} - 26'(v);
      return p[23:16];
   endfunction

   // saturate a component to the 16 bit field
   function automatic logic [15:0] sat16(logic signed [16:0] c);
      return (c > 17'sd32767) ? 16'h7FFF : c[15:0];
   endfunction

endpackage

// ----- hdl/sphere_reflection_map_coords.sv -----
// sphere reflection vector, colour codes and lat-long map coordinates,
// one pixel per clock while the output is not stalled
//  channel  direction  payload
//  req_     in         tdata: pixel_x, pixel_y
//  rsp_     out        tuser: inside_res; tdata: refl xyz, codes xyz, tex_col, tex_row
//
// 23 register stages, one word accepted per clock while the output is not stalled.
// the depth is set by the two 16 digit square roots and the 18 step angle rotator.
// reset clears the stage valid bits only; data registers hold no reset.
// a stall at the output freezes every stage together, so nothing is lost or repeated.
module sphere_reflection_map_coords (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_x [8:0], pixel_y [17:9], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // refl_x, refl_y, refl_z, code_x, code_y, code_z,
                                    // tex_col, tex_row, zero pad
   output logic [0:0]  rsp_tuser    // inside_res
);

   localparam int NST       = 23;
   localparam int SQA_FIRST = 3;
   localparam int SQB_FIRST = 11;
   localparam int ROT_INIT  = 15;
   localparam int ROT_FIRST = 16;
   localparam int ROT_PER   = 3;
   localparam int LAST      = NST - 1;

   srmc_pkg::item_type pipe_ff [NST];
   srmc_pkg::item_type pipe_in [NST];
   logic [NST-1:0]     valid_ff;
   logic [NST-1:0]     valid_in;
   logic               advance;

   // whole pipeline moves when the output word is free or being taken
   assign advance    = !valid_ff[LAST] || rsp_tready;
   assign req_tready = advance;
   assign valid_in   = {valid_ff[NST-2:0], req_tvalid};

   // stage logic
   always_comb begin
      logic signed [8:0]  xs;
      logic signed [8:0]  ys;
      logic signed [17:0] sqx;
      logic signed [17:0] sqy;
      logic signed [19:0] num;
      logic [31:0]        nzrem;
      logic [15:0]        nz2;
      logic [32:0]        rzrem;
      logic [16:0]        mag;
      logic signed [33:0] rysq;
      logic [31:0]        n;
      srmc_pkg::sqrt_type s;
      srmc_pkg::cordic_type ca;
      srmc_pkg::cordic_type ci;
      logic signed [21:0] az_a;
      logic signed [21:0] inc_a;
      logic [19:0]        u;
      logic [19:0]        incc;
      logic [20:0]        colsum;
      logic [20:0]        rowsum;
      logic [10:0]        rowv;
      int                 g;

      for (int k = 1; k < NST; k++) pipe_in[k] = pipe_ff[k-1];

      // stage 0: squares and magnitudes
      pipe_in[0]    = '0;
      xs            = $signed(req_tdata[8:0]);
      ys            = $signed(req_tdata[17:9]);
      sqx           = xs * xs;
      sqy           = ys * ys;
      pipe_in[0].d2 = $unsigned(sqx) + $unsigned(sqy);
      pipe_in[0].sx = xs[8];
      pipe_in[0].sy = ys[8];
      pipe_in[0].ax = xs[8] ? 9'(-xs) : 9'(xs);
      pipe_in[0].ay = ys[8] ? 9'(-ys) : 9'(ys);

      // stage 1: disc test, z squared estimate
      pipe_in[1].in_disc = (pipe_ff[0].d2 <= 18'(srmc_pkg::RADIUS_SQ));
      pipe_in[1].t       = pipe_in[1].in_disc ? 16'(18'(srmc_pkg::RADIUS_SQ) - pipe_ff[0].d2)
                                              : '0;
      num               = 20'(srmc_pkg::RADIUS_SQ) - $signed({1'b0, pipe_ff[0].d2, 1'b0});
      pipe_in[1].nneg   = num[19];
      pipe_in[1].anum   = num[19] ? 16'(-num) : 16'(num);
      pipe_in[1].qe     = 16'((48'(pipe_in[1].t) * 48'(srmc_pkg::NZ_RECIP))
                              >> srmc_pkg::NZ_SHIFT);

      // stage 2: z squared correction, rz estimate
      nzrem = 32'({1'b0, pipe_ff[1].t, 15'b0}) - 32'(pipe_ff[1].qe) * 32'(srmc_pkg::RADIUS_SQ);
      nz2   = (nzrem >= 32'(srmc_pkg::RADIUS_SQ)) ? 16'(pipe_ff[1].qe + 16'd1) : pipe_ff[1].qe;
      pipe_in[2].sq_n = {1'b0, nz2, 15'b0};
      pipe_in[2].sq   = '0;
      pipe_in[2].p2   = {pipe_ff[1].anum, 16'b0} + 32'(srmc_pkg::RADIUS_SQ);
      pipe_in[2].rzq  = 16'((50'(pipe_in[2].p2) * 50'(srmc_pkg::RZ_RECIP))
                            >> srmc_pkg::RZ_SHIFT);

      // stage 3: rz correction and clamp
      rzrem = 33'(pipe_ff[2].p2) - 33'(pipe_ff[2].rzq) * 33'(2 * srmc_pkg::RADIUS_SQ);
      mag   = (rzrem >= 33'(2 * srmc_pkg::RADIUS_SQ)) ? 17'(pipe_ff[2].rzq + 16'd1)
                                                      : 17'(pipe_ff[2].rzq);
      if (mag > 17'(srmc_pkg::ONE)) mag = 17'(srmc_pkg::ONE);
      pipe_in[3].rz = pipe_ff[2].nneg ? -$signed(mag) : $signed(mag);

      // stages 3 to 6: z square root, four digits each
      for (int k = SQA_FIRST; k < SQA_FIRST + 4; k++) begin
         s = pipe_ff[k-1].sq;
         n = pipe_ff[k-1].sq_n;
         for (int j = 0; j < 4; j++) begin
            g = (k - SQA_FIRST) * 4 + j;
            s = srmc_pkg::sqrt_step(s, n[31 - 2*g -: 2]);
         end
         pipe_in[k].sq = s;
      end

      // stage 7: lateral numerators
      pipe_in[7].px = 25'((25'(pipe_ff[6].ax) * 25'(pipe_ff[6].sq.root)) << 2)
                      + 25'(srmc_pkg::SPHERE_RADIUS);
      pipe_in[7].py = 25'((25'(pipe_ff[6].ay) * 25'(pipe_ff[6].sq.root)) << 2)
                      + 25'(srmc_pkg::SPHERE_RADIUS);

      // stage 8: lateral quotient estimates
      pipe_in[8].qx = 17'((51'(pipe_ff[7].px) * 51'(srmc_pkg::LAT_RECIP)) >> srmc_pkg::LAT_SHIFT);
      pipe_in[8].qy = 17'((51'(pipe_ff[7].py) * 51'(srmc_pkg::LAT_RECIP)) >> srmc_pkg::LAT_SHIFT);

      // stage 9: lateral correction, clamp and sign
      pipe_in[9].rx = srmc_pkg::lat_fix(pipe_ff[8].px, pipe_ff[8].qx, pipe_ff[8].sx);
      pipe_in[9].ry = srmc_pkg::lat_fix(pipe_ff[8].py, pipe_ff[8].qy, pipe_ff[8].sy);

      // stage 10: horizontal length squared for the inclination
      rysq             = pipe_ff[9].ry * pipe_ff[9].ry;
      pipe_in[10].sq_n = (32'd1 << (2 * srmc_pkg::FRAC_BITS)) - rysq[31:0];
      pipe_in[10].sq   = '0;

      // stages 11 to 14: horizontal length square root
      for (int k = SQB_FIRST; k < SQB_FIRST + 4; k++) begin
         s = pipe_ff[k-1].sq;
         n = pipe_ff[k-1].sq_n;
         for (int j = 0; j < 4; j++) begin
            g = (k - SQB_FIRST) * 4 + j;
            s = srmc_pkg::sqrt_step(s, n[31 - 2*g -: 2]);
         end
         pipe_in[k].sq = s;
      end

      // stage 15: rotator set-up for azimuth and inclination
      pipe_in[ROT_INIT].az       = srmc_pkg::cordic_init(pipe_ff[ROT_INIT-1].rz,
                                                         pipe_ff[ROT_INIT-1].rx);
      pipe_in[ROT_INIT].az_zero  = (pipe_ff[ROT_INIT-1].rz == '0) && (pipe_ff[ROT_INIT-1].rx == '0);
      pipe_in[ROT_INIT].inc      = srmc_pkg::cordic_init(17'(-pipe_ff[ROT_INIT-1].ry),
                                      $signed({1'b0, pipe_ff[ROT_INIT-1].sq.root}));
      pipe_in[ROT_INIT].inc_zero = (pipe_ff[ROT_INIT-1].ry == '0)
                                   && (pipe_ff[ROT_INIT-1].sq.root == '0);

      // stages 16 to 21: three micro-rotations each
      for (int k = ROT_FIRST; k < ROT_FIRST + srmc_pkg::CORDIC_STEPS / ROT_PER; k++) begin
         ca = pipe_ff[k-1].az;
         ci = pipe_ff[k-1].inc;
         for (int j = 0; j < ROT_PER; j++) begin
            g  = (k - ROT_FIRST) * ROT_PER + j;
            ca = srmc_pkg::cordic_step(ca, g);
            ci = srmc_pkg::cordic_step(ci, g);
         end
         pipe_in[k].az  = ca;
         pipe_in[k].inc = ci;
      end

      // last stage: map indices, codes, saturation, zero outside
      az_a   = pipe_ff[LAST-1].az_zero ? '0 : pipe_ff[LAST-1].az.acc;
      u      = 20'(az_a + 22'(srmc_pkg::HALF_TURN));
      colsum = 21'(u) + 21'(1 << (srmc_pkg::COL_SHIFT - 1));
      inc_a  = pipe_ff[LAST-1].inc_zero ? '0 : pipe_ff[LAST-1].inc.acc;
      if (inc_a < 0) incc = '0;
      else if (inc_a > 22'(srmc_pkg::HALF_TURN)) incc = 20'(srmc_pkg::HALF_TURN);
      else incc = 20'(inc_a);
      rowsum = 21'(incc) + 21'(1 << (srmc_pkg::COL_SHIFT - 1));
      rowv   = rowsum[20:srmc_pkg::COL_SHIFT];
      if (rowv >= 11'(srmc_pkg::MAP_HEIGHT)) rowv = 11'(srmc_pkg::MAP_HEIGHT - 1);
      if (pipe_ff[LAST-1].in_disc) begin
         pipe_in[LAST].o_rx  = srmc_pkg::sat16(pipe_ff[LAST-1].rx);
         pipe_in[LAST].o_ry  = srmc_pkg::sat16(pipe_ff[LAST-1].ry);
         pipe_in[LAST].o_rz  = srmc_pkg::sat16(pipe_ff[LAST-1].rz);
         pipe_in[LAST].o_cx  = srmc_pkg::colour(pipe_ff[LAST-1].rx);
         pipe_in[LAST].o_cy  = srmc_pkg::colour(pipe_ff[LAST-1].ry);
         pipe_in[LAST].o_cz  = srmc_pkg::colour(pipe_ff[LAST-1].rz);
         pipe_in[LAST].o_col = colsum[srmc_pkg::COL_SHIFT + 9 : srmc_pkg::COL_SHIFT];
         pipe_in[LAST].o_row = rowv[8:0];
      end else begin
         pipe_in[LAST].o_rx  = '0;
         pipe_in[LAST].o_ry  = '0;
         pipe_in[LAST].o_rz  = '0;
         pipe_in[LAST].o_cx  = '0;
         pipe_in[LAST].o_cy  = '0;
         pipe_in[LAST].o_cz  = '0;
         pipe_in[LAST].o_col = '0;
         pipe_in[LAST].o_row = '0;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

   // result word
   assign rsp_tvalid = valid_ff[LAST];
   assign rsp_tuser  = pipe_ff[LAST].in_disc;
   assign rsp_tdata  = {5'b0, pipe_ff[LAST].o_row, pipe_ff[LAST].o_col,
                        pipe_ff[LAST].o_cz, pipe_ff[LAST].o_cy, pipe_ff[LAST].o_cx,
                        pipe_ff[LAST].o_rz, pipe_ff[LAST].o_ry, pipe_ff[LAST].o_rx};

   // no word presented right after reset
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // pixels outside the disc give an all-zero word
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("outside pixel with non-zero result");

   // a negative x component never encodes above mid grey
   a_code_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && rsp_tdata[15] |-> !rsp_tdata[55])
      else $error("colour code disagrees with component sign");

   // a stall freezes the occupancy of every stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("stage valid bits moved during a stall");

endmodule
